/* src/fsr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the searchable FIFO queue.
// Used by the controller, the datapath and the top level; no dependencies.
package fsr_pkg;

    // Default number of entries the queue can hold.
    localparam int DEPTH_DEFAULT = 16;

    // Field widths of one input transaction and one result transaction.
    localparam int ACT_W   = 2;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 4;
    localparam int CNT_W   = 5;
    localparam int IN_RAW  = ACT_W + VAL_W;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = STAT_W + POS_W + CNT_W + VAL_W + VAL_W + 1;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH,
        ST_SHIFT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // latch the input transaction
        logic append;      // write at the tail unless full
        logic walk_init;   // restart the entry walk from the head
        logic search;      // walk looking for the first match
        logic shift_init;  // start compaction just past the match
        logic shift;       // walk moving entries one place toward the head
        logic shrink;      // drop one entry from the count
        logic scan;        // walk tracking minimum and maximum
        logic emit;        // load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACT_W-1:0] act;       // latched action code
        logic             match;     // the entry read back equals the value
        logic             walk_end;  // every held entry has been visited
        logic             out_free;  // the result register can take a result
    } dp_stat_t;

endpackage

/* src/fifo_with_search_and_remove_core.sv */
`timescale 1ns / 1ps
// An ordered queue of up to DEPTH signed 32-bit values with append, remove-first-match
// and find-first-match. Each input transaction yields one result transaction carrying
// the status, the match position and the count, minimum, maximum and empty flag after
// the action. One transaction is worked at a time. The held entries are walked through an
// entry memory with one read port and one write port and registered read data. An item is
// accepted, then dispatched; a search walks from the head to the first match or past the
// tail, and after a removal a compaction moves the entries past the match one place toward
// the head. A min/max rescan of the entries held after the action follows, and the result
// is loaded once the result register is free. The result register lets a new transaction
// be taken while the previous result waits.
// No clearing pass is needed after reset.
module fifo_with_search_and_remove_core
    import fsr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // action[1:0], value[33:2], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], position[5:2], entry_count[10:6],
                                        // smallest[42:11], largest[74:43], is_empty[75]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer for the action, walk and result phases.
    fsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Entry storage and arithmetic.
    fsr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

/* src/fsr_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine for the searchable FIFO queue.
// Depends on fsr_pkg; drives the datapath through dp_cmd_t.
module fsr_ctrl
    import fsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.act == ACT_REMOVE || stat.act == ACT_FIND)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SEARCH:
            begin
                priority if (stat.match && stat.act == ACT_REMOVE)
                begin
                    state_next = ST_SHIFT;
                end
                else if (stat.match || stat.walk_end)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SHIFT:
            begin
                if (stat.walk_end)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.walk_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DISPATCH:
            begin
                cmd.append    = (stat.act == ACT_APPEND);
                cmd.walk_init = 1'b1;
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                priority if (stat.match && stat.act == ACT_REMOVE)
                begin
                    cmd.shift_init = 1'b1;
                end
                else if (stat.match || stat.walk_end)
                begin
                    cmd.walk_init = 1'b1;
                end
                else
                begin
                    cmd.walk_init = 1'b0;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.walk_end)
                begin
                    cmd.shrink    = 1'b1;
                    cmd.walk_init = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* src/fsr_dp.sv */
`timescale 1ns / 1ps
// Datapath for the searchable FIFO queue: entry memory, walk counter,
// match detection, compaction, min/max tracking and the result register.
// Depends on fsr_pkg; commanded by fsr_ctrl.
module fsr_dp
    import fsr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat
);

    localparam int IW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PAD = OUT_W - OUT_RAW;

    // Entry memory, head at index 0.
    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    logic [ACT_W-1:0]  act_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CW-1:0]     count_reg,  count_next;
    logic [CW-1:0]     idx_reg,    idx_next;
    logic              pend_reg,   pend_next;
    logic [IW-1:0]     pidx_reg,   pidx_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [IW-1:0]     pos_reg,    pos_next;
    logic signed [VAL_W-1:0] lo_reg, lo_next;
    logic signed [VAL_W-1:0] hi_reg, hi_next;
    logic              have_reg,   have_next;
    logic              out_vld_reg, out_vld_next;
    logic [OUT_W-1:0]  out_reg,    out_next;

    logic full;
    logic walking;
    logic issue;
    logic match;
    logic walk_end;

    assign full     = (count_reg == CW'(DEPTH));
    assign walking  = cmd.search || cmd.shift || cmd.scan;
    assign issue    = walking && (idx_reg < count_reg);
    assign match    = pend_reg && (rd_data_reg == val_reg);
    assign walk_end = !pend_reg && (idx_reg >= count_reg);

    // Memory port: reads follow the walk index, writes come from append or compaction.
    assign rd_addr = idx_reg[IW-1:0];
    assign wr_en   = (cmd.append && !full) || (cmd.shift && pend_reg);
    assign wr_addr = cmd.append ? count_reg[IW-1:0] : (pidx_reg - IW'(1));
    assign wr_data = cmd.append ? val_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // Next values of the walk, counters and result fields.
    always_comb
    begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        pend_next    = issue;
        pidx_next    = issue ? idx_reg[IW-1:0] : pidx_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        have_next    = have_reg;
        out_vld_next = out_vld_reg;
        out_next     = out_reg;

        if (issue)
        begin
            idx_next = idx_reg + CW'(1);
        end

        // Restarting the walk takes precedence over stepping it.
        priority if (cmd.shift_init)
        begin
            idx_next  = CW'(pidx_reg) + CW'(1);
            pend_next = 1'b0;
        end
        else if (cmd.walk_init)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
            lo_next   = '0;
            hi_next   = '0;
            have_next = 1'b0;
        end
        else
        begin
            idx_next = idx_next;
        end

        // Status and position of the action.
        priority if (cmd.load)
        begin
            status_next = STAT_OK;
            pos_next    = '0;
        end
        else if (cmd.append && full)
        begin
            status_next = STAT_FULL;
        end
        else if (cmd.search && match)
        begin
            pos_next = pidx_reg;
        end
        else if (cmd.search && walk_end)
        begin
            status_next = STAT_NOT_FOUND;
        end
        else
        begin
            status_next = status_reg;
        end

        // Entry count.
        if (cmd.append && !full)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.shrink)
        begin
            count_next = count_reg - CW'(1);
        end

        // Running minimum and maximum.
        if (cmd.scan && pend_reg)
        begin
            if (!have_reg)
            begin
                lo_next   = rd_data_reg;
                hi_next   = rd_data_reg;
                have_next = 1'b1;
            end
            else
            begin
                if ($signed(rd_data_reg) < lo_reg)
                begin
                    lo_next = rd_data_reg;
                end
                if ($signed(rd_data_reg) > hi_reg)
                begin
                    hi_next = rd_data_reg;
                end
            end
        end

        // Result register.
        if (cmd.emit)
        begin
            out_vld_next = 1'b1;
            out_next     = {PAD'(0), (count_reg == '0), hi_reg, lo_reg,
                            CNT_W'(count_reg), POS_W'(pos_reg), status_reg};
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            idx_reg     <= '0;
            have_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            idx_reg     <= idx_next;
            have_reg    <= have_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= s_tdata[ACT_W-1:0];
            val_reg <= s_tdata[ACT_W +: VAL_W];
        end
        pidx_reg   <= pidx_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        out_reg    <= out_next;
    end

    assign m_tvalid      = out_vld_reg;
    assign m_tdata       = out_reg;
    assign stat.act      = act_reg;
    assign stat.match    = match;
    assign stat.walk_end = walk_end;
    assign stat.out_free = !out_vld_reg || m_tready;

endmodule

/* sim/fifo_with_search_and_remove_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the searchable FIFO queue core.
// Drives append, remove, find and unused-code transactions with random gaps and back-pressure, and
// checks every result against a behavioral queue model; depends on fsr_pkg and the core.
module fifo_with_search_and_remove_core_test;
    import fsr_pkg::*;

    localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
    localparam int DRAIN_CYCLES = 3 * QUEUE_DEPTH + 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    // The fourth action code has no meaning and must leave the queue untouched.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    // Input transaction layout, lowest field in the lowest bits.
    typedef struct packed {
        logic [IN_W-IN_RAW-1:0] pad;
        logic signed [VAL_W-1:0] value;
        logic [ACT_W-1:0]        action;
    } request_t;

    // Result transaction layout, lowest field in the lowest bits.
    typedef struct packed {
        logic [OUT_W-OUT_RAW-1:0] pad;
        logic                     is_empty;
        logic signed [VAL_W-1:0]  largest;
        logic signed [VAL_W-1:0]  smallest;
        logic [CNT_W-1:0]         entry_count;
        logic [POS_W-1:0]         position;
        logic [STAT_W-1:0]        status;
    } result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;    // action[1:0], value[33:2], zero pad
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;    // status[1:0], position[5:2], entry_count[10:6],
                                  // smallest[42:11], largest[74:43], is_empty[75]

    // Behavioral copy of the queue contents.
    logic signed [VAL_W-1:0] model_slots [QUEUE_DEPTH];
    int                      model_count = 0;

    result_t pending_results [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;

    bit sender_idle = 1'b0;
    bit receiver_idle = 1'b0;
    int hold_requested = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;

    fifo_with_search_and_remove_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Apply one action to the queue model and return the result it must produce.
    function automatic result_t predict_queue_result(input logic [ACT_W-1:0] act,
                                                     input logic [VAL_W-1:0] val);
        result_t                 r;
        int                      hit;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        r   = '0;
        hit = -1;
        lo  = '0;
        hi  = '0;
        if (act == ACT_APPEND)
        begin
            if (model_count >= QUEUE_DEPTH)
                r.status = STAT_FULL;
            else
            begin
                model_slots[model_count] = val;
                model_count++;
            end
        end
        else if (act == ACT_REMOVE || act == ACT_FIND)
        begin
            for (int i = 0; i < model_count; i++)
                if (hit < 0 && model_slots[i] == val)
                    hit = i;
            if (hit < 0)
                r.status = STAT_NOT_FOUND;
            else
            begin
                r.position = hit[POS_W-1:0];
                // A removal closes the gap so the order from the head is kept.
                if (act == ACT_REMOVE)
                begin
                    for (int i = hit; i + 1 < model_count; i++)
                        model_slots[i] = model_slots[i + 1];
                    model_count--;
                end
            end
        end
        // Statistics are always taken after the action.
        if (model_count > 0)
        begin
            lo = model_slots[0];
            hi = model_slots[0];
            for (int i = 1; i < model_count; i++)
            begin
                if (model_slots[i] < lo)
                    lo = model_slots[i];
                if (model_slots[i] > hi)
                    hi = model_slots[i];
            end
        end
        r.entry_count = model_count[CNT_W-1:0];
        r.smallest    = lo;
        r.largest     = hi;
        r.is_empty    = (model_count == 0);
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Values favor what is held and a small pool with duplicates, so searches hit.
    function automatic logic [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && model_count > 0)
            return model_slots[$urandom_range(0, model_count - 1)];
        if (sel < 7)
            return $urandom_range(0, 15) - 8;
        if (sel == 7)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom();
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(input int append_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return ACT_UNUSED;
        if (r < 3 + append_weight)
            return ACT_APPEND;
        return $urandom_range(0, 1) ? ACT_REMOVE : ACT_FIND;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want)
            note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    endtask

    // Offer one input transaction and record its expected result once accepted.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val);
        int       gap;
        request_t req;
        gap        = sender_idle ? pick_gap() : 0;
        req        = '0;
        req.action = act;
        req.value  = val;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_queue_result(act, val));
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requested)
            begin
                hold_served = hold_requested;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (receiver_idle && $urandom_range(0, 99) < 30)
            begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
                note_failure("result transaction with no pending expectation");
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("position", want.position, got.position);
                check_field("entry_count", want.entry_count, got.entry_count);
                check_field("smallest", want.smallest, got.smallest);
                check_field("largest", want.largest, got.largest);
                check_field("is_empty", want.is_empty, got.is_empty);
            end
        end
    end

    // Searches, removals and the unused code on an empty queue.
    task automatic test_empty_queue();
        send_item(ACT_FIND, 32'h0000_0000);
        send_item(ACT_REMOVE, 32'hffff_ffff);
        send_item(ACT_UNUSED, 32'h1234_5678);
    endtask

    // Fill with extremes and duplicates, then append once more to hit full.
    task automatic test_fill_to_full();
        send_item(ACT_APPEND, 32'h8000_0000);
        send_item(ACT_APPEND, 32'h7fff_ffff);
        send_item(ACT_APPEND, 32'h0000_0000);
        send_item(ACT_APPEND, 32'hffff_ffff);
        send_item(ACT_APPEND, 32'd7);
        send_item(ACT_APPEND, 32'd7);
        for (int i = 0; i < QUEUE_DEPTH - 6; i++)
            send_item(ACT_APPEND, i * 1000 + 100);
        send_item(ACT_APPEND, 32'h5555_aaaa);
    endtask

    // Find near the head, in the middle and at the tail, then remove in the middle, at the tail and at the head.
    task automatic test_search_and_remove();
        send_item(ACT_FIND, 32'h7fff_ffff);
        send_item(ACT_FIND, (QUEUE_DEPTH - 7) * 1000 + 100);
        send_item(ACT_FIND, 32'd7);
        send_item(ACT_REMOVE, 32'd7);
        send_item(ACT_REMOVE, (QUEUE_DEPTH - 7) * 1000 + 100);
        send_item(ACT_REMOVE, 32'h8000_0000);
        send_item(ACT_UNUSED, 32'hdead_beef);
    endtask

    // Random traffic in segments that lean toward filling or draining the queue.
    task automatic test_random_traffic(input int n_items);
        int append_weight;
        append_weight = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       append_weight = 25;
                    1:       append_weight = 50;
                    default: append_weight = 80;
                endcase
            end
            send_item(pick_action(append_weight), pick_value());
        end
    endtask

    // The result side holds off while the input side keeps offering transactions.
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle = sender_idle;
        sender_idle = 1'b0;
        hold_requested++;
        test_random_traffic(40);
        sender_idle = saved_idle;
    endtask

    // The input side pauses until every outstanding result has arrived.
    task automatic test_pause_until_drained();
        test_random_traffic(100);
        stop_sending();
        wait_drained();
        test_random_traffic(100);
    endtask

    // Test sequence.
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        test_empty_queue();
        test_fill_to_full();
        test_search_and_remove();

        test_random_traffic(600);
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        test_random_traffic(300);
        test_backpressure();
        sender_idle = 1'b1;
        test_random_traffic(400);
        test_pause_until_drained();
        sender_idle   = 1'b0;
        receiver_idle = 1'b1;
        test_random_traffic(300);

        stop_sending();
        wait_drained();
        if (pending_results.size() != 0)
            note_failure("expected results left over at the end");
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
